[sv/bsb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bsb_pkg;

    // Request codes carried in the cmd field.
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Blit modes.
    typedef enum logic [1:0] {
        MODE_COPY  = 2'd0,
        MODE_XOR   = 2'd1,
        MODE_ERASE = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    // Operation held in the modify stage.
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_DATA  = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    // Result kinds.
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Result queue depth and the width of its fill count.
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    // Control word handed from the issue stage to the modify stage.
    typedef struct packed {
        logic       valid;
        op_t        op;
        mode_t      mode;
        logic       wr;        // data byte lands inside the memory
        logic       done;      // this request finishes the blit
        logic       rd_ok;     // read address lies inside the memory
        logic       fwd_hit;   // memory data is stale, use fwd_data
        logic [7:0] fwd_data;
        logic [7:0] src;
    } stage_t;

    // One result word.
    typedef struct packed {
        logic       kind;
        logic [7:0] value;
    } result_t;

endpackage

`default_nettype wire

[sv/bitmap_sprite_blitter.sv]
// Each result goes through the stage register and then the result queue before it
// shows on out_valid. Throughput: one request per cycle, start, data byte or read,
// sustained while the result queue has room; the single read-modify-write pass
// through the video memory sets that rate.
// Reset: rst_n clears all control state at once, then the memory is zeroed one byte
// per cycle, COLUMNS * BYTES_PER_COLUMN bytes (7168 by default), with in_ready low.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_sprite_blitter #(
    parameter int COLUMNS          = 224,
    parameter int BYTES_PER_COLUMN = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [1:0]  blit_mode,
    input  wire logic [7:0]  column,
    input  wire logic [4:0]  byte_row,
    input  wire logic [5:0]  width_bytes,
    input  wire logic [7:0]  height_cols,
    input  wire logic [7:0]  data_byte,
    input  wire logic [12:0] read_addr,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             kind,
    output logic [7:0]       value
);

    import bsb_pkg::*;

    localparam int MEM_DEPTH = COLUMNS * BYTES_PER_COLUMN;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // The design is a two-stage pipeline wrapped around one video memory.
    // The issue stage decodes each request, steps the blit counters and
    // launches the memory read. In the next cycle the modify stage gets the
    // read data, applies the blit mode, writes the byte back and produces
    // any result. A write that leaves the modify stage in the same cycle a
    // read of the same byte is launched is forwarded, so overlapping rows
    // of a wide sprite and reads right after a blit see fresh data.

    logic              accept;
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;
    logic [7:0]        rdata;
    stage_t            stage;
    logic [MEM_AW-1:0] stage_addr;
    logic              ram_we;
    logic [MEM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              clearing;
    logic              fifo_push;
    result_t           fifo_push_data;
    logic              fifo_pop;
    result_t           fifo_head;
    logic [OUTQ_CW-1:0] fifo_count;

    // The modify stage never stalls, so a request is taken only when the
    // result queue has room for it and for the request already in flight.
    // This keeps a full pipeline moving while results wait to be taken.
    assign in_ready = !clearing
                    && ((OUTQ_CW + 1)'(fifo_count) + (OUTQ_CW + 1)'(stage.valid)
                        < (OUTQ_CW + 1)'(OUTQ_DEPTH));
    assign accept   = in_valid && in_ready;
    assign fifo_pop = out_valid && out_ready;

    bsb_issue #(
        .COLUMNS          (COLUMNS),
        .BYTES_PER_COLUMN (BYTES_PER_COLUMN)
    ) u_issue (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .cmd         (cmd),
        .blit_mode   (blit_mode),
        .column      (column),
        .byte_row    (byte_row),
        .width_bytes (width_bytes),
        .height_cols (height_cols),
        .data_byte   (data_byte),
        .read_addr   (read_addr),
        .mod_we      (ram_we),
        .mod_waddr   (ram_waddr),
        .mod_wdata   (ram_wdata),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .stage       (stage),
        .stage_addr  (stage_addr)
    );

    // Video memory: one write port owned by the modify stage (and by the
    // reset sweep), one read port owned by the issue stage.
    bsb_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_vram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    bsb_modify #(
        .COLUMNS          (COLUMNS),
        .BYTES_PER_COLUMN (BYTES_PER_COLUMN)
    ) u_modify (
        .clk        (clk),
        .rst_n      (rst_n),
        .stage      (stage),
        .stage_addr (stage_addr),
        .rdata      (rdata),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .clearing   (clearing),
        .push       (fifo_push),
        .push_data  (fifo_push_data)
    );

    // Results queue here, in request order, until the consumer takes them.
    bsb_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fifo_push),
        .push_data  (fifo_push_data),
        .pop        (fifo_pop),
        .head_valid (out_valid),
        .head_data  (fifo_head),
        .count      (fifo_count)
    );

    assign kind  = fifo_head.kind;
    assign value = fifo_head.value;

    // The admission rule must keep the result queue from overflowing.
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> (fifo_count != OUTQ_CW'(OUTQ_DEPTH)) || fifo_pop)
        else $error("result queue overflow");

    // No request may reach the modify stage while the memory is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !stage.valid)
        else $error("request in flight during memory clear");

    // A forwarded byte must come from a write made in the previous cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage.valid && stage.fwd_hit) |-> $past(ram_we))
        else $error("forwarding without a preceding write");

endmodule

`default_nettype wire

[sv/bsb_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[sv/bsb_issue.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsb_issue #(
    parameter int COLUMNS          = 224,
    parameter int BYTES_PER_COLUMN = 32,
    parameter int MEM_DEPTH        = COLUMNS * BYTES_PER_COLUMN,
    parameter int MEM_AW           = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [1:0]          cmd,
    input  wire logic [1:0]          blit_mode,
    input  wire logic [7:0]          column,
    input  wire logic [4:0]          byte_row,
    input  wire logic [5:0]          width_bytes,
    input  wire logic [7:0]          height_cols,
    input  wire logic [7:0]          data_byte,
    input  wire logic [12:0]         read_addr,
    input  wire logic                mod_we,
    input  wire logic [MEM_AW-1:0]   mod_waddr,
    input  wire logic [7:0]          mod_wdata,
    output logic                     rd_en,
    output logic      [MEM_AW-1:0]   rd_addr,
    output bsb_pkg::stage_t          stage,
    output logic      [MEM_AW-1:0]   stage_addr
);

    import bsb_pkg::*;

    // Room for the largest origin plus a full run of columns and bytes.
    localparam int CALC_W = $clog2(512 * BYTES_PER_COLUMN + 128);

    mode_t             mode_reg, mode_next;
    logic [CALC_W-1:0] row_base_reg, row_base_next;
    logic [5:0]        width_reg, width_next;
    logic [7:0]        height_reg, height_next;
    logic [5:0]        bc_reg, bc_next;
    logic [7:0]        cc_reg, cc_next;
    logic              active_reg, active_next;
    stage_t            stage_reg, stage_next;
    logic [MEM_AW-1:0] stage_addr_reg, stage_addr_next;

    logic [CALC_W-1:0] start_base;
    logic [CALC_W-1:0] data_addr;
    logic [31:0]       data_addr_ext;
    logic [31:0]       read_addr_ext;
    logic              data_in_range;
    logic              read_in_range;
    logic [6:0]        bc_inc;
    logic [8:0]        cc_inc;
    logic              col_wrap;
    logic              last_byte;

    always_comb
    begin
        start_base    = CALC_W'(column) * CALC_W'(BYTES_PER_COLUMN) + CALC_W'(byte_row);
        data_addr     = row_base_reg + CALC_W'(bc_reg);
        data_addr_ext = 32'(data_addr);
        read_addr_ext = 32'(read_addr);
        data_in_range = data_addr_ext < 32'(MEM_DEPTH);
        read_in_range = read_addr_ext < 32'(MEM_DEPTH);
        bc_inc        = 7'(bc_reg) + 7'd1;
        cc_inc        = 9'(cc_reg) + 9'd1;
        col_wrap      = bc_inc >= 7'(width_reg);
        last_byte     = col_wrap && (cc_inc >= 9'(height_reg));
    end

    always_comb
    begin
        mode_next       = mode_reg;
        row_base_next   = row_base_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        bc_next         = bc_reg;
        cc_next         = cc_reg;
        active_next     = active_reg;
        stage_next      = '0;
        stage_addr_next = stage_addr_reg;
        rd_en           = 1'b0;
        rd_addr         = MEM_AW'(data_addr_ext);

        if (accept)
        begin
            case (cmd_t'(cmd))
                CMD_START:
                begin
                    mode_next        = mode_t'(blit_mode);
                    row_base_next    = start_base;
                    width_next       = width_bytes;
                    height_next      = height_cols;
                    bc_next          = '0;
                    cc_next          = '0;
                    active_next      = (width_bytes != 6'd0) && (height_cols != 8'd0);
                    stage_next.valid = 1'b1;
                    stage_next.op    = OP_START;
                    stage_next.mode  = mode_t'(blit_mode);
                    stage_next.done  = (width_bytes == 6'd0) || (height_cols == 8'd0);
                end
                CMD_DATA:
                begin
                    if (active_reg)
                    begin
                        rd_en            = data_in_range;
                        rd_addr          = MEM_AW'(data_addr_ext);
                        stage_next.valid = 1'b1;
                        stage_next.op    = OP_DATA;
                        stage_next.mode  = mode_reg;
                        stage_next.wr    = data_in_range;
                        stage_next.done  = last_byte;
                        stage_next.src   = data_byte;
                        stage_addr_next  = MEM_AW'(data_addr_ext);
                        if (col_wrap)
                        begin
                            bc_next       = '0;
                            cc_next       = cc_inc[7:0];
                            row_base_next = row_base_reg + CALC_W'(BYTES_PER_COLUMN);
                        end
                        else
                        begin
                            bc_next = bc_inc[5:0];
                        end
                        if (last_byte)
                        begin
                            active_next = 1'b0;
                        end
                    end
                end
                CMD_READ:
                begin
                    rd_en            = read_in_range;
                    rd_addr          = MEM_AW'(read_addr_ext);
                    stage_next.valid = 1'b1;
                    stage_next.op    = OP_READ;
                    stage_next.rd_ok = read_in_range;
                end
                default:
                begin
                end
            endcase
        end

        // The write leaving the modify stage this cycle is not yet visible
        // to a read of the same address.
        stage_next.fwd_hit  = rd_en && mod_we && (mod_waddr == rd_addr);
        stage_next.fwd_data = mod_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_COPY;
            row_base_reg <= '0;
            width_reg    <= 6'd1;
            height_reg   <= 8'd1;
            bc_reg       <= '0;
            cc_reg       <= '0;
            active_reg   <= 1'b0;
            stage_reg    <= '0;
        end
        else
        begin
            mode_reg     <= mode_next;
            row_base_reg <= row_base_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            bc_reg       <= bc_next;
            cc_reg       <= cc_next;
            active_reg   <= active_next;
            stage_reg    <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_addr_reg <= stage_addr_next;
    end

    assign stage      = stage_reg;
    assign stage_addr = stage_addr_reg;

endmodule

`default_nettype wire

[sv/bsb_modify.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsb_modify #(
    parameter int COLUMNS          = 224,
    parameter int BYTES_PER_COLUMN = 32,
    parameter int MEM_DEPTH        = COLUMNS * BYTES_PER_COLUMN,
    parameter int MEM_AW           = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bsb_pkg::stage_t   stage,
    input  wire logic [MEM_AW-1:0] stage_addr,
    input  wire logic [7:0]        rdata,
    output logic                   ram_we,
    output logic      [MEM_AW-1:0] ram_waddr,
    output logic      [7:0]        ram_wdata,
    output logic                   clearing,
    output logic                   push,
    output bsb_pkg::result_t       push_data
);

    import bsb_pkg::*;

    logic              clearing_reg, clearing_next;
    logic [MEM_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [7:0]        accum_reg, accum_next;

    logic [7:0] cur;
    logic [7:0] res;
    logic       data_wr;
    logic [7:0] done_value;

    always_comb
    begin
        cur     = stage.fwd_hit ? stage.fwd_data : rdata;
        data_wr = stage.valid && (stage.op == OP_DATA) && stage.wr;

        case (stage.mode)
            MODE_COPY:  res = stage.src;
            MODE_XOR:   res = cur ^ stage.src;
            MODE_ERASE: res = cur & ~stage.src;
            default:    res = 8'd0;
        endcase

        accum_next = accum_reg;
        if (stage.valid && (stage.op == OP_START))
        begin
            accum_next = 8'd0;
        end
        else if (data_wr && (stage.mode == MODE_XOR))
        begin
            accum_next = accum_reg | res;
        end
        done_value = (stage.mode == MODE_XOR) ? accum_next : 8'd0;

        // Reset sweep: one entry zeroed per cycle.
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + MEM_AW'(1);
            if (clr_cnt_reg == MEM_AW'(MEM_DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end

        ram_we    = clearing_reg || data_wr;
        ram_waddr = clearing_reg ? clr_cnt_reg : stage_addr;
        ram_wdata = clearing_reg ? 8'd0 : res;

        push = stage.valid && ((stage.op == OP_READ) || stage.done);
        if (stage.op == OP_READ)
        begin
            push_data.kind  = KIND_READ;
            push_data.value = stage.rd_ok ? cur : 8'd0;
        end
        else
        begin
            push_data.kind  = KIND_DONE;
            push_data.value = done_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            accum_reg    <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
            accum_reg    <= accum_next;
        end
    end

    assign clearing = clearing_reg;

endmodule

`default_nettype wire

[sv/bsb_out_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsb_out_fifo (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire bsb_pkg::result_t              push_data,
    input  wire logic                          pop,
    output logic                               head_valid,
    output bsb_pkg::result_t                   head_data,
    output logic [bsb_pkg::OUTQ_CW-1:0]        count
);

    import bsb_pkg::*;

    localparam int PW = $clog2(OUTQ_DEPTH);

    result_t          entries_reg [OUTQ_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + OUTQ_CW'(push) - OUTQ_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_data  = entries_reg[rd_ptr_reg];
    assign count      = count_reg;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

// Testbench for the sprite blitter. A shadow copy of the video memory and of the
// blit registers is updated for every request that the block accepts. Each result
// that the block is expected to produce is queued, and a checker compares every
// result leaving the block against the oldest queued one.
module tb_top;

    import bsb_pkg::*;

    localparam int COLS         = 224;
    localparam int BPC          = 32;
    localparam int VRAM_BYTES   = COLS * BPC;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1770;
    // A result goes through the stage register and the result queue after its request
    // is taken; the wait also covers any stage still busy after the last result is seen.
    localparam int SETTLE_CYCLES = 8;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [1:0]  blit_mode;
    logic [7:0]  column;
    logic [4:0]  byte_row;
    logic [5:0]  width_bytes;
    logic [7:0]  height_cols;
    logic [7:0]  data_byte;
    logic [12:0] read_addr;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        kind;
    logic [7:0]  value;

    bitmap_sprite_blitter #(
        .COLUMNS          (COLS),
        .BYTES_PER_COLUMN (BPC)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .blit_mode   (blit_mode),
        .column      (column),
        .byte_row    (byte_row),
        .width_bytes (width_bytes),
        .height_cols (height_cols),
        .data_byte   (data_byte),
        .read_addr   (read_addr),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .value       (value)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Shadow of the video memory and of the registers latched by a start request.
    logic [7:0]  shadow_vram [VRAM_BYTES];
    int unsigned shadow_base;
    logic [5:0]  shadow_width;
    logic [7:0]  shadow_height;
    mode_t       shadow_mode;
    int unsigned shadow_byte;
    int unsigned shadow_col;
    logic [7:0]  shadow_collision;
    logic        shadow_active;

    // Results the block owes us, oldest first.
    result_t pending_results[$];

    int error_count = 0;
    int burst_left  = 0;
    // Start of the most recent sprite, so that reads can land where data was written.
    int unsigned last_sprite_base = 0;

    // Apply one accepted request to the shadow state and queue any result it causes.
    function automatic void shadow_blit_step(
        input cmd_t        c,
        input mode_t       m,
        input logic [7:0]  col,
        input logic [4:0]  row,
        input logic [5:0]  w,
        input logic [7:0]  h,
        input logic [7:0]  d,
        input logic [12:0] ra
    );
        int unsigned a;
        logic [7:0]  cur;
        logic [7:0]  res;
        result_t     r;
        case (c)
            CMD_START:
            begin
                shadow_mode      = m;
                shadow_base      = int'(col) * BPC + int'(row);
                shadow_width     = w;
                shadow_height    = h;
                shadow_byte      = 0;
                shadow_col       = 0;
                shadow_collision = 8'h00;
                // An empty sprite finishes on the start request itself.
                if (w == 0 || h == 0)
                begin
                    shadow_active = 1'b0;
                    r.kind        = KIND_DONE;
                    r.value       = 8'h00;
                    pending_results.push_back(r);
                end
                else
                begin
                    shadow_active = 1'b1;
                end
            end
            CMD_DATA:
            begin
                // Data with no blit in progress is dropped without a result.
                if (shadow_active)
                begin
                    a = shadow_base + shadow_col * BPC + shadow_byte;
                    // Bytes that fall past the memory end are lost but still counted.
                    if (a < VRAM_BYTES)
                    begin
                        cur = shadow_vram[a];
                        case (shadow_mode)
                            MODE_COPY:  res = d;
                            MODE_XOR:
                            begin
                                res = cur ^ d;
                                shadow_collision |= res;
                            end
                            MODE_ERASE: res = cur & ~d;
                            default:    res = 8'h00;
                        endcase
                        shadow_vram[a] = res;
                    end
                    shadow_byte++;
                    if (shadow_byte >= shadow_width)
                    begin
                        shadow_byte = 0;
                        shadow_col++;
                        if (shadow_col >= shadow_height)
                        begin
                            shadow_active = 1'b0;
                            r.kind        = KIND_DONE;
                            r.value       = (shadow_mode == MODE_XOR) ? shadow_collision
                                                                      : 8'h00;
                            pending_results.push_back(r);
                        end
                    end
                end
            end
            CMD_READ:
            begin
                r.kind  = KIND_READ;
                r.value = (ra < VRAM_BYTES) ? shadow_vram[ra] : 8'h00;
                pending_results.push_back(r);
            end
            default:
            begin
            end
        endcase
    endfunction

    // Send one request. The sender works in bursts; at the start of each burst it
    // may leave in_valid low before its first request. Once valid is raised the payload
    // holds until the block takes it.
    task automatic send_req(
        input cmd_t        c,
        input mode_t       m,
        input logic [7:0]  col,
        input logic [4:0]  row,
        input logic [5:0]  w,
        input logic [7:0]  h,
        input logic [7:0]  d,
        input logic [12:0] ra
    );
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        cmd         <= c;
        blit_mode   <= m;
        column      <= col;
        byte_row    <= row;
        width_bytes <= w;
        height_cols <= h;
        data_byte   <= d;
        read_addr   <= ra;
        do
            @(posedge clk);
        while (!in_ready);
        shadow_blit_step(c, m, col, row, w, h, d, ra);
    endtask

    // Fields a request does not use get random values, so that every bit of every
    // field toggles and the block is seen to ignore them.
    task automatic send_start(input mode_t m, input logic [7:0] col, input logic [4:0] row,
                              input logic [5:0] w, input logic [7:0] h);
        send_req(CMD_START, m, col, row, w, h, 8'($urandom_range(0, 255)),
                 13'($urandom_range(0, 8191)));
        last_sprite_base = int'(col) * BPC + int'(row);
    endtask

    task automatic send_data(input logic [7:0] d);
        send_req(CMD_DATA, mode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                 8'($urandom_range(0, 255)), d, 13'($urandom_range(0, 8191)));
    endtask

    task automatic send_read(input logic [12:0] ra);
        send_req(CMD_READ, mode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), ra);
    endtask

    task automatic send_unused_cmd();
        send_req(CMD_NONE, mode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 13'($urandom_range(0, 8191)));
    endtask

    // Memory must read back as zero after reset, and reads past the end give zero.
    task automatic test_reads_after_reset();
        send_read(13'd0);
        send_read(13'(VRAM_BYTES - 1));
        send_read(13'(VRAM_BYTES));
        send_read(13'h1FFF);
    endtask

    // A zero width or a zero height finishes on the start request.
    task automatic test_empty_sprite();
        send_start(MODE_XOR, 8'd3, 5'd4, 6'd0, 8'd5);
        send_start(MODE_COPY, 8'd3, 5'd4, 6'd3, 8'd0);
    endtask

    // Run every mode over the same 2x2 patch and read it back in between.
    task automatic test_each_mode();
        send_start(MODE_COPY, 8'd0, 5'd0, 6'd2, 8'd2);
        send_data(8'hFF);
        send_data(8'h00);
        send_data(8'hA5);
        send_data(8'h5A);
        send_start(MODE_XOR, 8'd0, 5'd0, 6'd2, 8'd2);
        send_data(8'h0F);
        send_data(8'h0F);
        send_data(8'h5A);
        send_data(8'h5A);
        send_read(13'd0);
        send_read(13'd33);
        send_start(MODE_ERASE, 8'd0, 5'd0, 6'd2, 8'd2);
        send_data(8'h30);
        send_data(8'hFF);
        send_data(8'h00);
        send_data(8'h81);
        send_read(13'd32);
        send_start(MODE_CLEAR, 8'd0, 5'd0, 6'd2, 8'd2);
        repeat (4) send_data(8'hFF);
        // Xor of zero over cleared memory leaves the collision value at zero.
        send_start(MODE_XOR, 8'd0, 5'd0, 6'd1, 8'd1);
        send_data(8'h00);
        send_read(13'd1);
    endtask

    // Bytes past the memory end are dropped but still advance the blit.
    task automatic test_write_past_end();
        send_start(MODE_COPY, 8'd223, 5'd30, 6'd2, 8'd2);
        send_data(8'h11);
        send_data(8'h22);
        send_data(8'h33);
        send_data(8'h44);
        send_read(13'(VRAM_BYTES - 1));
        send_start(MODE_XOR, 8'd255, 5'd31, 6'd1, 8'd1);
        send_data(8'hFF);
    endtask

    // Data with no blit open and the unused command both produce nothing.
    task automatic test_idle_and_unused();
        send_data(8'hC3);
        send_unused_cmd();
        send_read(13'd7166);
    endtask

    // A new start drops the blit in progress; a read in the middle of a blit is
    // served without disturbing it.
    task automatic test_restart_and_read_during_blit();
        send_start(MODE_COPY, 8'd100, 5'd7, 6'd2, 8'd2);
        send_data(8'h77);
        send_start(MODE_XOR, 8'd100, 5'd7, 6'd2, 8'd1);
        send_data(8'h07);
        send_read(13'(100 * BPC + 7));
        send_data(8'hE0);
        send_read(13'(100 * BPC + 8));
    endtask

    // A sprite wider than a column overlaps its own rows, and the byte counter
    // runs up to 62, the highest that a width of 63 allows.
    task automatic test_wide_sprite();
        int i;
        send_start(MODE_COPY, 8'd50, 5'd31, 6'd63, 8'd2);
        for (i = 0; i < 126; i++)
            send_data(8'($urandom_range(0, 255)));
        for (i = 0; i < 4; i++)
            send_read(13'(50 * BPC + 31 + $urandom_range(0, 93)));
    endtask

    // Mostly complete sprites with random origin, size, mode and content; reads
    // scattered through them; now and then a sprite cut short by a new start,
    // stray data with no blit open, or the unused command.
    task automatic test_random();
        int          items;
        int          pick;
        int          sz;
        int          total;
        int          cut;
        int          i;
        mode_t       m;
        logic [7:0]  col;
        logic [5:0]  w;
        logic [7:0]  h;
        logic [7:0]  d;
        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                m = mode_t'($urandom_range(0, 3));
                // Keep most sprites in two areas so that modes pile up on each
                // other and xor blits see collisions.
                case ($urandom_range(0, 3))
                    0:       col = 8'($urandom_range(0, 255));
                    1:       col = 8'($urandom_range(218, 223));
                    default: col = 8'($urandom_range(0, 7));
                endcase
                sz = $urandom_range(0, 99);
                if (sz < 86)
                begin
                    w = 6'($urandom_range(1, 4));
                    h = 8'($urandom_range(1, 4));
                end
                else if (sz < 92)
                begin
                    w = 6'($urandom_range(33, 63));
                    h = 8'($urandom_range(1, 2));
                end
                else if (sz < 96)
                begin
                    w = 6'd32;
                    h = 8'($urandom_range(1, 3));
                end
                else if (sz < 97)
                begin
                    w = 6'd1;
                    h = 8'($urandom_range(200, 255));
                end
                else
                begin
                    w = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
                    h = (w == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
                end
                send_start(m, col, 5'($urandom_range(0, 31)), w, h);
                items++;
                total = int'(w) * int'(h);
                // A few sprites are abandoned part way through.
                cut = ($urandom_range(0, 29) == 0 && total > 1) ?
                      $urandom_range(1, total - 1) : total;
                for (i = 0; i < cut; i++)
                begin
                    case ($urandom_range(0, 7))
                        0:       d = 8'h00;
                        1:       d = 8'hFF;
                        default: d = 8'($urandom_range(0, 255));
                    endcase
                    send_data(d);
                    items++;
                    if ($urandom_range(0, 7) == 0)
                    begin
                        send_read(13'((last_sprite_base + $urandom_range(0, 70)) & 13'h1FFF));
                        items++;
                    end
                end
            end
            else if (pick < 88)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_read(13'($urandom_range(0, 8191)));
                else
                    send_read(13'((last_sprite_base + $urandom_range(0, 100)) & 13'h1FFF));
                items++;
            end
            else if (pick < 94)
            begin
                // Only sent with no blit open, so the block must drop it.
                if (!shadow_active)
                    send_data(8'($urandom_range(0, 255)));
            end
            else
            begin
                send_unused_cmd();
            end
        end
    endtask

    // Receiver stalls: when rx_tick[7:0] is zero, pick a new style, from always
    // ready to long regular stalls, so backpressure hits every phase of the pipeline.
    logic [15:0] rx_tick  = 16'd0;
    logic [1:0]  rx_style = 2'd0;

    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 16'd1;
        if (rx_tick[7:0] == 8'd0)
            rx_style <= 2'($urandom_range(0, 3));
        case (rx_style)
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
            2'd2:    out_ready <= (rx_tick[3:0] < 4'd5);
            default: out_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Every result leaving the block is checked against the oldest one owed.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with none expected: kind %0b value 0x%02h", kind, value);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0b, actual %0b", want.kind, kind);
                    error_count++;
                end
                if (value !== want.value)
                begin
                    $error("value: expected 0x%02h, actual 0x%02h", want.value, value);
                    error_count++;
                end
            end
        end
    end

    // Watchdog. The run, including the memory clear after reset, stays far below
    // this even with the worst stalls on both sides.
    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL bitmap_sprite_blitter");
            $finish;
        end
    end

    initial
    begin
        int i;
        for (i = 0; i < VRAM_BYTES; i++)
            shadow_vram[i] = 8'h00;
        shadow_base      = 0;
        shadow_width     = 6'd1;
        shadow_height    = 8'd1;
        shadow_mode      = MODE_COPY;
        shadow_byte      = 0;
        shadow_col       = 0;
        shadow_collision = 8'h00;
        shadow_active    = 1'b0;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        cmd         <= CMD_NONE;
        blit_mode   <= MODE_COPY;
        column      <= 8'd0;
        byte_row    <= 5'd0;
        width_bytes <= 6'd0;
        height_cols <= 8'd0;
        data_byte   <= 8'd0;
        read_addr   <= 13'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // The sender waits on in_ready, so the memory clear after reset needs no
        // special handling here.
        test_reads_after_reset();
        test_empty_sprite();
        test_each_mode();
        test_write_past_end();
        test_idle_and_unused();
        test_restart_and_read_during_blit();
        test_wide_sprite();
        test_random();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        // Anything still waiting at the output is a result nobody asked for.
        if (out_valid)
        begin
            $error("out_valid: expected 0, actual %0b", out_valid);
            error_count++;
        end

        if (error_count == 0)
            $display("PASS bitmap_sprite_blitter");
        else
            $display("FAIL bitmap_sprite_blitter");
        $finish;
    end

endmodule

[sim.f]
sv/bsb_pkg.sv
sv/bsb_ram.sv
sv/bsb_issue.sv
sv/bsb_modify.sv
sv/bsb_out_fifo.sv
sv/bitmap_sprite_blitter.sv
tb/sv/tb_top.sv
